>>> rtl/fpa_pkg.sv
// Shared opcodes, constants and saturation helpers for the fixed-point ALU.
package fpa_pkg;

	localparam int FRAC_BITS_DEF = 8;

	typedef enum logic [3:0] {
		OP_ADD     = 4'd0,
		OP_SUB     = 4'd1,
		OP_MUL     = 4'd2,
		OP_DIV     = 4'd3,
		OP_GT      = 4'd4,
		OP_LT      = 4'd5,
		OP_GE      = 4'd6,
		OP_LE      = 4'd7,
		OP_EQ      = 4'd8,
		OP_NE      = 4'd9,
		OP_MIN     = 4'd10,
		OP_MAX     = 4'd11,
		OP_INC     = 4'd12,
		OP_DEC     = 4'd13,
		OP_TOINT   = 4'd14,
		OP_FROMINT = 4'd15
	} op_t;

	typedef struct packed {
		logic [31:0] res;
		logic        ovf;
	} sat_t;

	localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
	localparam logic [31:0] MIN32 = 32'h8000_0000;

	// clamp a 33-bit signed sum to 32 bits
	function automatic sat_t sat33(input logic [32:0] v);
		sat_t r;
		r.ovf = v[32] ^ v[31];
		r.res = r.ovf ? (v[32] ? MIN32 : MAX32) : v[31:0];
		return r;
	endfunction

	// apply a sign to a magnitude and clamp to 32 bits
	function automatic sat_t sat_mag(input logic [63:0] m, input logic neg);
		sat_t r;
		if (neg) begin
			r.ovf = m > 64'h0000_0000_8000_0000;
			r.res = r.ovf ? MIN32 : (~m[31:0] + 32'd1);
		end else begin
			r.ovf = m > 64'h0000_0000_7FFF_FFFF;
			r.res = r.ovf ? MAX32 : m[31:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/fixed_point_alu_core.sv
// Top level of the pipelined signed fixed-point ALU.
//
// Usage: drive opcode, operand_a and operand_b and raise start; the item is
// taken at any rising edge where start is high and busy is low. busy stays
// low, so a new item may enter on every clock cycle.
// Each item gives one result: result_value, compare_true, overflow and
// divide_by_zero are shown for one cycle with result_valid high.
// Every opcode takes equally long from the accepting edge to the edge that
// takes the result; the divider, one quotient bit per stage over
// 32 + FRAC_BITS stages, sets that span.
// Other opcodes ride a delay line so results leave in input order.
// Throughput is one item per cycle.
// Reset clears all valid bits; items in flight are dropped and no result
// appears until a new item passes through.
// The receiver cannot stall: each result must be taken in its cycle.
module fixed_point_alu_core import fpa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         opcode,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               result_valid,
	output logic signed [31:0] result_value,
	output logic               compare_true,
	output logic               overflow,
	output logic               divide_by_zero
);

	localparam int QW  = 32 + FRAC_BITS;
	localparam int DLY = QW - 1;

	assign busy = 1'b0;

	// stage 1: capture item
	logic               vld_s1;
	op_t                op_s1;
	logic signed [31:0] a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1 <= op_t'(opcode);
			a_s1  <= operand_a;
			b_s1  <= operand_b;
		end
	end

	// magnitudes and sign for mul and div
	logic [31:0] mag_a, mag_b, toint_m;
	logic        neg;
	assign mag_a   = a_s1[31] ? (~a_s1 + 32'd1) : a_s1;
	assign mag_b   = b_s1[31] ? (~b_s1 + 32'd1) : b_s1;
	assign neg     = a_s1[31] ^ b_s1[31];
	assign toint_m = mag_a >> FRAC_BITS;

	// simple ops resolved in stage 1
	logic [32:0] sum33, dif33, inc33, dec33;
	logic [63:0] fi64;
	sat_t        simp;
	logic        cmp;

	assign sum33 = {a_s1[31], a_s1} + {b_s1[31], b_s1};
	assign dif33 = {a_s1[31], a_s1} - {b_s1[31], b_s1};
	assign inc33 = {a_s1[31], a_s1} + 33'd1;
	assign dec33 = {a_s1[31], a_s1} - 33'd1;
	assign fi64  = {{32{a_s1[31]}}, a_s1} << FRAC_BITS;

	always_comb begin
		simp = '0;
		cmp  = 1'b0;
		case (op_s1)
			OP_ADD:   simp = sat33(sum33);
			OP_SUB:   simp = sat33(dif33);
			OP_GT:    cmp = a_s1 > b_s1;
			OP_LT:    cmp = a_s1 < b_s1;
			OP_GE:    cmp = a_s1 >= b_s1;
			OP_LE:    cmp = a_s1 <= b_s1;
			OP_EQ:    cmp = a_s1 == b_s1;
			OP_NE:    cmp = a_s1 != b_s1;
			OP_MIN:   simp.res = (a_s1 < b_s1) ? a_s1 : b_s1;
			OP_MAX:   simp.res = (a_s1 > b_s1) ? a_s1 : b_s1;
			OP_INC:   simp = sat33(inc33);
			OP_DEC:   simp = sat33(dec33);
			OP_TOINT: simp.res = a_s1[31] ? (~toint_m + 32'd1) : toint_m;
			OP_FROMINT: begin
				simp.ovf = (fi64[63:31] != '0) && (fi64[63:31] != '1);
				simp.res = simp.ovf ? (fi64[63] ? MIN32 : MAX32) : fi64[31:0];
			end
			default: simp = '0;
		endcase
	end

	// stage 2: product registered
	logic        vld_s2, neg_s2, cmp_s2, dz_s2;
	op_t         op_s2;
	sat_t        simp_s2;
	logic [63:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			op_s2   <= op_s1;
			neg_s2  <= neg;
			cmp_s2  <= cmp;
			dz_s2   <= (op_s1 == OP_DIV) && (b_s1 == '0);
			simp_s2 <= simp;
			prod_s2 <= mag_a * mag_b;
		end
	end

	// stage 3: round product half away from zero, clamp
	logic [63:0] mul_m;
	sat_t        mul_r;
	assign mul_m = (prod_s2 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
	assign mul_r = sat_mag(mul_m, neg_s2);

	typedef struct packed {
		op_t  op;
		logic neg;
		logic cmp;
		logic dz;
		sat_t res;
	} side_t;

	logic  vld_d [0:DLY];
	side_t side_d [0:DLY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_d[0] <= 1'b0;
		else         vld_d[0] <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			side_d[0].op  <= op_s2;
			side_d[0].neg <= neg_s2;
			side_d[0].cmp <= cmp_s2;
			side_d[0].dz  <= dz_s2;
			side_d[0].res <= (op_s2 == OP_MUL) ? mul_r : simp_s2;
		end
	end

	// delay line to meet the divider output
	for (genvar k = 0; k < DLY; k++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_d[k+1] <= 1'b0;
			else         vld_d[k+1] <= vld_d[k];
		end

		always_ff @(posedge clk) begin
			if (vld_d[k]) side_d[k+1] <= side_d[k];
		end
	end

	// divider runs beside the main path; zero divisors never enter it
	logic        div_vld;
	logic [QW:0] div_q;

	fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1 && (op_s1 == OP_DIV) && (b_s1 != '0)),
		.num_mag   (mag_a),
		.den       (mag_b),
		.out_valid (div_vld),
		.quot      (div_q)
	);

	// final merge and output register
	side_t fin;
	sat_t  div_r;
	assign fin   = side_d[DLY];
	assign div_r = sat_mag(64'(div_q), fin.neg);

	logic        out_vld_q;
	logic [31:0] res_q;
	logic        cmp_q, ovf_q, dz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else         out_vld_q <= vld_d[DLY];
	end

	always_ff @(posedge clk) begin
		if (vld_d[DLY]) begin
			cmp_q <= fin.cmp;
			dz_q  <= fin.dz;
			if (fin.op == OP_DIV) begin
				res_q <= fin.dz ? '0 : div_r.res;
				ovf_q <= fin.dz ? 1'b0 : div_r.ovf;
			end else begin
				res_q <= fin.res.res;
				ovf_q <= fin.res.ovf;
			end
		end
	end

	assign result_valid   = out_vld_q;
	assign result_value   = res_q;
	assign compare_true   = cmp_q;
	assign overflow       = ovf_q;
	assign divide_by_zero = dz_q;

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, QW + 3))
		else $error("result without matching item");

	a_div_align: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_d[DLY] && fin.op == OP_DIV && !fin.dz) |-> div_vld)
		else $error("divider out of step with delay line");

	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && divide_by_zero) |-> (result_value == '0 && !overflow))
		else $error("divide by zero result not cleared");

	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && compare_true) |-> (result_value == '0 && !overflow))
		else $error("comparison carried a value");

endmodule

>>> rtl/fpa_div.sv
// Pipelined restoring divider, one quotient bit per stage, rounds half up.
module fpa_div import fpa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [31:0]           num_mag,
	input  logic [31:0]           den,
	output logic                  out_valid,
	output logic [32+FRAC_BITS:0] quot
);

	localparam int QW = 32 + FRAC_BITS;

	logic          vld_s [0:QW];
	logic [31:0]   rem_s [0:QW];
	logic [QW-1:0] nq_s  [0:QW];
	logic [31:0]   den_s [0:QW];

	logic          vld_r_s;
	logic [QW:0]   quot_r_s;

	// stage 0 is the input side
	assign vld_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign nq_s[0]  = {num_mag, {FRAC_BITS{1'b0}}};
	assign den_s[0] = den;

	// one trial subtract per stage; numerator bits shift out as quotient bits shift in
	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [32:0] trial;
		logic        ge;
		logic [31:0] rem_n;
		assign trial = {rem_s[k], nq_s[k][QW-1]};
		assign ge    = trial >= {1'b0, den_s[k]};
		assign rem_n = ge ? 32'(trial - {1'b0, den_s[k]}) : trial[31:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else         vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (vld_s[k]) begin
				rem_s[k+1] <= rem_n;
				nq_s[k+1]  <= {nq_s[k][QW-2:0], ge};
				den_s[k+1] <= den_s[k];
			end
		end
	end

	// round half up: twice the remainder against the divisor
	logic up;
	assign up = {rem_s[QW], 1'b0} >= {1'b0, den_s[QW]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_r_s <= 1'b0;
		else         vld_r_s <= vld_s[QW];
	end

	always_ff @(posedge clk) begin
		if (vld_s[QW]) quot_r_s <= {1'b0, nq_s[QW]} + {{QW{1'b0}}, up};
	end

	assign out_valid = vld_r_s;
	assign quot      = quot_r_s;

	// remainder stays below a nonzero divisor
	a_rem_lt_den: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[QW] && den_s[QW] != '0) |-> (rem_s[QW] < den_s[QW]))
		else $error("divider remainder not below divisor");

	a_vld_follow: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QW] |=> vld_r_s)
		else $error("divider round stage lost an item");

	a_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		vld_r_s |-> !quot_r_s[QW])
		else $error("divider quotient wrapped");

endmodule
